>>> rtl/wsu_pkg.sv
// Shared types and constants for the WebSocket frame unmasker.
package wsu_pkg;

  // Default width of the payload length counter
  localparam int unsigned LEN_WIDTH_DEF = 64;

  // Length codes in the second header byte
  localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
  localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

  // Extended length byte counts
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;

  // Result status codes
  localparam logic STATUS_DATA  = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  // Raw byte held in the input register
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } in_stage_t;

  // One result item
  typedef struct packed {
    logic [7:0] data_out;
    logic       last;
    logic       status;
  } result_t;

  // Result handed from the core to the output register
  typedef struct packed {
    logic    valid;
    result_t res;
  } res_stage_t;

endpackage

>>> rtl/wsu_if.sv
// Valid/ready channel interfaces for the raw byte input and the result output.
interface wsu_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

interface wsu_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_out;
  logic       last;
  logic       status;

  modport source (output valid, output data_out, output last, output status, input ready);
  modport sink   (input valid, input data_out, input last, input status, output ready);
endinterface

>>> rtl/websocket_frame_unmasker.sv
// Top level of the WebSocket frame unmasker.
//
// Raw frame bytes enter on byte_i (valid/ready, one byte per transfer). The
// first header byte is skipped, the second selects a 7-bit, 16-bit or 64-bit
// payload length, four mask key bytes follow, and each payload byte leaves on
// res_o XORed with key byte (payload index mod 4); the final payload byte of a
// frame has last set. Header and key bytes give no result.
// A frame with zero length gives one result with status set and data_out and
// last clear, and every later byte is taken and dropped until reset.
// A byte is captured in the input register, parsed by the core from there,
// and its result is registered in the output register before it is offered.
// Throughput is one byte per cycle while the receiver takes results: input
// register, parser and output register advance together.
// When the receiver stalls, the output register holds its result and the
// input register holds one more byte; byte_i.ready then drops.
// Reset empties both registers and returns the parser to the first header byte.
module websocket_frame_unmasker #(
  parameter int unsigned LEN_WIDTH = wsu_pkg::LEN_WIDTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  wsu_byte_if.sink       byte_i,
  wsu_res_if.source      res_o
);

  wsu_pkg::in_stage_t  in_stage;
  wsu_pkg::res_stage_t res_stage;
  wsu_pkg::result_t    res_out;
  logic                adv;
  logic                space;

  // Input register
  wsu_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (byte_i.valid),
    .data_i  (byte_i.byte_in),
    .ready_o (byte_i.ready),
    .adv_i   (adv),
    .stage_o (in_stage)
  );

  // Frame parser and unmasking
  wsu_core #(
    .LEN_WIDTH (LEN_WIDTH)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .stage_i (in_stage),
    .space_i (space),
    .adv_o   (adv),
    .res_o   (res_stage)
  );

  // Result register
  wsu_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .res_i   (res_stage),
    .space_o (space),
    .valid_o (res_o.valid),
    .ready_i (res_o.ready),
    .res_o   (res_out)
  );

  assign res_o.data_out = res_out.data_out;
  assign res_o.last     = res_out.last;
  assign res_o.status   = res_out.status;

endmodule

>>> rtl/wsu_in_reg.sv
// Input register: captures one raw byte per transfer.
module wsu_in_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [7:0]          data_i,
  output logic                ready_o,
  input  logic                adv_i,
  output wsu_pkg::in_stage_t  stage_o
);

  logic       valid_q, valid_d;
  logic [7:0] data_q;
  logic       load;

  // Free when empty or when the held byte moves on this cycle
  assign ready_o = !valid_q || adv_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (adv_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_i;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.data  = data_q;

endmodule

>>> rtl/wsu_core.sv
// Frame parser: header, extended length, mask key and payload unmasking.
module wsu_core #(
  parameter int unsigned LEN_WIDTH = wsu_pkg::LEN_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  wsu_pkg::in_stage_t   stage_i,
  input  logic                 space_i,
  output logic                 adv_o,
  output wsu_pkg::res_stage_t  res_o
);

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXT,
    PH_KEY,
    PH_DATA
  } phase_e;

  phase_e               phase_q, phase_d;
  logic [3:0]           ext_left_q, ext_left_d;
  logic [LEN_WIDTH-1:0] rem_len_q, rem_len_d;
  logic [31:0]          key_q, key_d;
  logic [1:0]           key_cnt_q, key_cnt_d;
  logic [1:0]           mask_idx_q, mask_idx_d;
  logic                 halted_q, halted_d;

  logic [7:0]           b;
  logic [6:0]           code;
  logic [7:0]           key_byte;
  logic [LEN_WIDTH-1:0] rem_dec;

  // The held byte moves on whenever the output side has room
  assign adv_o    = stage_i.valid && space_i;
  assign b        = stage_i.data;
  assign code     = b[6:0];
  assign key_byte = key_q[8*mask_idx_q +: 8];
  assign rem_dec  = rem_len_q - LEN_WIDTH'(1);

  // Next state and result
  always_comb begin
    phase_d    = phase_q;
    ext_left_d = ext_left_q;
    rem_len_d  = rem_len_q;
    key_d      = key_q;
    key_cnt_d  = key_cnt_q;
    mask_idx_d = mask_idx_q;
    halted_d   = halted_q;
    res_o      = '0;

    if (adv_o && !halted_q) begin
      case (phase_q)
        PH_HDR1: begin
          rem_len_d = '0;
          if (code == wsu_pkg::LEN_CODE_EXT16) begin
            phase_d    = PH_EXT;
            ext_left_d = wsu_pkg::EXT16_BYTES;
          end else if (code == wsu_pkg::LEN_CODE_EXT64) begin
            phase_d    = PH_EXT;
            ext_left_d = wsu_pkg::EXT64_BYTES;
          end else begin
            rem_len_d = LEN_WIDTH'(code);
            phase_d   = PH_KEY;
            key_cnt_d = '0;
            key_d     = '0;
          end
        end
        PH_EXT: begin
          // Big-endian shift-in; high bits fall off
          rem_len_d  = {rem_len_q[LEN_WIDTH-9:0], b};
          ext_left_d = ext_left_q - 4'd1;
          if (ext_left_q == 4'd1) begin
            phase_d   = PH_KEY;
            key_cnt_d = '0;
            key_d     = '0;
          end
        end
        PH_KEY: begin
          // Key byte 0 ends up in the low bits after four shifts
          key_d     = {b, key_q[31:8]};
          key_cnt_d = key_cnt_q + 2'd1;
          if (key_cnt_q == 2'd3) begin
            mask_idx_d = '0;
            if (rem_len_q == '0) begin
              halted_d          = 1'b1;
              phase_d           = PH_HDR0;
              res_o.valid       = 1'b1;
              res_o.res.status  = wsu_pkg::STATUS_EMPTY;
            end else begin
              phase_d = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          mask_idx_d          = mask_idx_q + 2'd1;
          rem_len_d           = rem_dec;
          res_o.valid         = 1'b1;
          res_o.res.data_out  = b ^ key_byte;
          res_o.res.last      = (rem_dec == '0);
          res_o.res.status    = wsu_pkg::STATUS_DATA;
          if (rem_dec == '0) begin
            phase_d = PH_HDR0;
          end
        end
        default: begin
          phase_d = PH_HDR1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HDR0;
      ext_left_q <= '0;
      rem_len_q  <= '0;
      key_q      <= '0;
      key_cnt_q  <= '0;
      mask_idx_q <= '0;
      halted_q   <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      ext_left_q <= ext_left_d;
      rem_len_q  <= rem_len_d;
      key_q      <= key_d;
      key_cnt_q  <= key_cnt_d;
      mask_idx_q <= mask_idx_d;
      halted_q   <= halted_d;
    end
  end

endmodule

>>> rtl/wsu_out_reg.sv
// Output register: holds one result until the receiver takes it.
module wsu_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  wsu_pkg::res_stage_t  res_i,
  output logic                 space_o,
  output logic                 valid_o,
  input  logic                 ready_i,
  output wsu_pkg::result_t     res_o
);

  logic             valid_q, valid_d;
  wsu_pkg::result_t res_q;

  // Room when empty or when the held result leaves this cycle
  assign space_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (space_o) begin
      valid_d = res_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (space_o && res_i.valid) begin
      res_q <= res_i.res;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

>>> bench/testbench.sv
// Self-checking testbench for the WebSocket frame unmasker: frame stimulus, predictor, checks.

// Framing of the payload length in the second header byte
typedef enum int unsigned {
  FORM_SHORT,
  FORM_EXT16,
  FORM_EXT64
} len_form_e;

// Parser position as the predictor tracks it
typedef enum logic [3:0] {
  PH_HDR0,
  PH_HDR1,
  PH_EXT,
  PH_KEY,
  PH_DATA
} parse_phase_e;

// Predicts unmasked payload bytes and checks them in order
class unmask_scoreboard;
  parse_phase_e         phase;
  logic [3:0]           ext_left;
  logic [63:0]          len_left;
  logic [31:0]          key;
  logic [2:0]           key_left;
  logic [1:0]           key_idx;
  bit                   halted;
  wsu_pkg::result_t     exp_q[$];
  int unsigned          errors;
  int unsigned          n_payload;
  int unsigned          n_frames;
  int unsigned          n_empty;
  int unsigned          n_dropped;

  function new();
    phase     = PH_HDR0;
    ext_left  = '0;
    len_left  = '0;
    key       = '0;
    key_left  = '0;
    key_idx   = '0;
    halted    = 1'b0;
    errors    = 0;
    n_payload = 0;
    n_frames  = 0;
    n_empty   = 0;
    n_dropped = 0;
  endfunction

  task report(input string msg);
    $display("%0t  MISMATCH  %s", $realtime, msg);
    errors++;
  endtask

  function int unsigned pending();
    return exp_q.size();
  endfunction

  function void load_key();
    phase    = PH_KEY;
    key_left = 3'd4;
    key      = '0;
  endfunction

  // Advance the parser by one accepted input byte
  function void note_byte(input logic [7:0] b);
    wsu_pkg::result_t r;
    logic [1:0]       k;
    logic [7:0]       kb;
    if (halted) begin
      n_dropped++;
      return;
    end
    case (phase)
      PH_HDR1: begin
        len_left = '0;
        if (b[6:0] == wsu_pkg::LEN_CODE_EXT16) begin
          phase    = PH_EXT;
          ext_left = wsu_pkg::EXT16_BYTES;
        end else if (b[6:0] == wsu_pkg::LEN_CODE_EXT64) begin
          phase    = PH_EXT;
          ext_left = wsu_pkg::EXT64_BYTES;
        end else begin
          len_left = {57'd0, b[6:0]};
          load_key();
        end
      end
      PH_EXT: begin
        len_left = {len_left[55:0], b};
        ext_left = ext_left - 4'd1;
        if (ext_left == 4'd0) load_key();
      end
      PH_KEY: begin
        k = 2'(3'd4 - key_left);
        key[8*k +: 8] = b;
        key_left = key_left - 3'd1;
        if (key_left == 3'd0) begin
          key_idx = 2'd0;
          if (len_left == '0) begin
            // empty payload: one error result, then everything is dropped
            halted     = 1'b1;
            phase      = PH_HDR0;
            r.data_out = 8'd0;
            r.last     = 1'b0;
            r.status   = wsu_pkg::STATUS_EMPTY;
            exp_q      = {exp_q, r};
          end else begin
            phase = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        kb         = key[8*key_idx +: 8];
        key_idx    = key_idx + 2'd1;
        len_left   = len_left - 64'd1;
        r.data_out = b ^ kb;
        r.last     = (len_left == '0);
        r.status   = wsu_pkg::STATUS_DATA;
        if (r.last) phase = PH_HDR0;
        exp_q      = {exp_q, r};
      end
      default: phase = PH_HDR1;
    endcase
  endfunction

  // Compare one output transfer with the oldest prediction
  task check_result(input wsu_pkg::result_t got);
    wsu_pkg::result_t want;
    if (exp_q.size() == 0) begin
      report($sformatf("unexpected result data=%02h last=%0b status=%0b",
                       got.data_out, got.last, got.status));
      return;
    end
    want = exp_q.pop_front();
    if (got.data_out !== want.data_out || got.last !== want.last ||
        got.status !== want.status) begin
      report($sformatf("got data=%02h last=%0b status=%0b, want data=%02h last=%0b status=%0b",
                       got.data_out, got.last, got.status,
                       want.data_out, want.last, want.status));
    end
    if (want.status == wsu_pkg::STATUS_EMPTY) n_empty++;
    else begin
      n_payload++;
      if (want.last) n_frames++;
    end
  endtask

  task finish_check();
    if (exp_q.size() != 0) report($sformatf("%0d results never arrived", exp_q.size()));
  endtask
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned N_BYTES    = 1600;
  localparam int unsigned HOLD_AT    = 400;
  localparam int unsigned HOLD_CYC   = 64;
  localparam int unsigned DRAIN_CYC  = 8;
  localparam int unsigned DRAIN_MAX  = 2000;

  // Opening frames: 16-bit length with key wrap, then 64-bit length, MASK clear
  localparam logic [7:0] OPENING [28] = '{
    8'h00, 8'hFE, 8'h00, 8'h05, 8'hFF, 8'h00, 8'hA5, 8'h5A,
    8'h00, 8'hFF, 8'h0F, 8'hF0, 8'hFF,
    8'hFF, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01,
    8'h00, 8'hFF, 8'h00, 8'hFF, 8'h80
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  wsu_byte_if byte_ch ();
  wsu_res_if  res_ch ();

  websocket_frame_unmasker u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_ch),
    .res_o  (res_ch)
  );

  unmask_scoreboard sb = new();

  int unsigned bytes_sent = 0;
  bit          hold_req   = 1'b0;
  bit          calm       = 1'b0;

  always #1 clk_i = ~clk_i;

  // Offer one byte and wait for its transfer; random gaps afterwards
  task automatic send_byte(input logic [7:0] b);
    byte_ch.valid   <= 1'b1;
    byte_ch.byte_in <= b;
    do @(posedge clk_i); while (!byte_ch.ready);
    sb.note_byte(b);
    bytes_sent++;
    if (!calm && $urandom_range(0, 5) == 0) begin
      byte_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  // Whole frame: header, length, random key, random payload
  task automatic send_frame(input int unsigned plen, input len_form_e form);
    logic [63:0] len64;
    logic        mask_bit;
    len64    = 64'(plen);
    mask_bit = 1'($urandom_range(0, 1));
    send_byte(8'($urandom_range(0, 255)));
    case (form)
      FORM_EXT16: begin
        send_byte({mask_bit, wsu_pkg::LEN_CODE_EXT16});
        send_byte(len64[15:8]);
        send_byte(len64[7:0]);
      end
      FORM_EXT64: begin
        send_byte({mask_bit, wsu_pkg::LEN_CODE_EXT64});
        for (int i = 7; i >= 0; i--) send_byte(len64[8*i +: 8]);
      end
      default: send_byte({mask_bit, len64[6:0]});
    endcase
    repeat (4) send_byte(8'($urandom_range(0, 255)));
    repeat (plen) send_byte(8'($urandom_range(0, 255)));
  endtask

  // Result side: check transfers, random stalls, one long hold-off
  initial begin
    int unsigned      stall_left;
    bit               held;
    wsu_pkg::result_t got;
    stall_left   = 0;
    held         = 1'b0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (res_ch.valid && res_ch.ready) begin
        got.data_out = res_ch.data_out;
        got.last     = res_ch.last;
        got.status   = res_ch.status;
        sb.check_result(got);
      end
      if (hold_req && !held) begin
        held       = 1'b1;
        stall_left = HOLD_CYC;
      end
      if (stall_left > 0) begin
        res_ch.ready <= 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        res_ch.ready <= 1'b0;
        stall_left = $urandom_range(0, 4);
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int unsigned plen;
    int unsigned pick;
    int unsigned guard;
    len_form_e   form;
    rst_ni          = 1'b0;
    byte_ch.valid   = 1'b0;
    byte_ch.byte_in = 8'h00;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (OPENING[i]) send_byte(OPENING[i]);

    // mostly short frames, some with 16- and 64-bit lengths, a few long ones
    while (bytes_sent < N_BYTES) begin
      if (bytes_sent > HOLD_AT) hold_req = 1'b1;
      if (bytes_sent > N_BYTES * 7 / 8) calm = 1'b1;
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        form = FORM_SHORT;
        plen = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 125) : $urandom_range(1, 12);
      end else begin
        form = (pick < 8) ? FORM_EXT16 : FORM_EXT64;
        plen = ($urandom_range(0, 9) == 0) ? $urandom_range(126, 600) : $urandom_range(1, 40);
      end
      send_frame(plen, form);
    end

    // empty frame halts the parser; what follows must be dropped
    send_frame(0, len_form_e'($urandom_range(0, 2)));
    repeat ($urandom_range(8, 16)) send_byte(8'($urandom_range(0, 255)));
    byte_ch.valid <= 1'b0;

    guard = 0;
    while (sb.pending() != 0 && guard < DRAIN_MAX) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (DRAIN_CYC) @(posedge clk_i);
    sb.finish_check();

    $display("summary: %0d bytes sent, %0d payload bytes checked in %0d frames",
             bytes_sent, sb.n_payload, sb.n_frames);
    $display("summary: %0d empty-frame rejections, %0d bytes dropped after halt",
             sb.n_empty, sb.n_dropped);
    if (sb.errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #200us;
    $display("testbench: done, errors");
    $finish;
  end
endmodule
